>>> hw/rtl/ods_pkg.sv
// Shared types and constants for the ordered deque store.
// Holds the operation, status and token-kind codes and the chain control struct.
// No dependencies.
package ods_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int OP_W         = 3;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 7;
   localparam int STATUS_W     = 3;

   typedef logic signed [DATA_W-1:0] ods_word_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT,
      OP_PUSH_REAR,
      OP_POP_FRONT,
      OP_POP_REAR,
      OP_ORDERED_INSERT,
      OP_DELETE_KEY,
      OP_DELETE_BEFORE,
      OP_READ
   } ods_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE,
      ST_EMPTY,
      ST_NOKEY,
      ST_BADPOS,
      ST_FULL
   } ods_status_type;

   typedef enum logic [1:0] {
      TK_NONE,
      TK_INSERT,
      TK_DELETE,
      TK_READ
   } ods_kind_type;

   typedef struct packed {
      logic         active;
      ods_kind_type kind;
      logic         search;
      logic         found;
   } ods_ctl_type;

endpackage

>>> hw/rtl/ods_req_if.sv
// Request channel interface: valid/ready handshake with op, value and position.
// Depends on ods_pkg.
interface ods_req_if import ods_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] data_value;
   logic [POS_W-1:0]         position;

   modport source (output valid, op, data_value, position, input ready);
   modport sink   (input valid, op, data_value, position, output ready);
endinterface

>>> hw/rtl/ods_rsp_if.sv
// Response channel interface: valid/ready handshake with status, value and count.
// Depends on ods_pkg.
interface ods_rsp_if import ods_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] out_value;
   logic [POS_W-1:0]         entry_count;

   modport source (output valid, status, out_value, entry_count, input ready);
   modport sink   (input valid, status, out_value, entry_count, output ready);
endinterface

>>> hw/rtl/ods_cell.sv
// One storage cell of the deque chain: holds one entry and passes the
// operation token, carry word and result word to the next cell each cycle.
// Depends on ods_pkg.
module ods_cell import ods_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  ods_ctl_type   ctl_in,
   input  ods_word_type  key_in,
   input  ods_word_type  carry_in,
   input  ods_word_type  result_in,
   input  logic [CW-1:0] occ_in,
   input  logic [CW-1:0] k_in,
   input  ods_word_type  next_entry,
   output ods_word_type  entry,
   output ods_ctl_type   ctl_out,
   output ods_word_type  key_out,
   output ods_word_type  carry_out,
   output ods_word_type  result_out,
   output logic [CW-1:0] occ_out,
   output logic [CW-1:0] k_out
);

   ods_word_type  entry_ff, entry_in;
   ods_ctl_type   ctl_ff, ctl_in_next;
   ods_word_type  key_ff, carry_ff, carry_in_next, result_ff, result_in_next;
   logic [CW-1:0] occ_ff, k_ff;
   logic          below, at_occ, hit_here, hit_now, shifting;

   assign below  = CW'(INDEX) < occ_in;
   assign at_occ = CW'(INDEX) == occ_in;

   always_comb begin
      hit_here = 1'b0;
      if (ctl_in.search) begin
         unique case (ctl_in.kind)
            TK_INSERT: hit_here = below ? !(entry_ff < key_in) : at_occ;
            TK_DELETE: hit_here = below && (entry_ff == key_in);
            default:   hit_here = 1'b0;
         endcase
      end else begin
         hit_here = (CW'(INDEX) == k_in);
      end
      hit_now  = ctl_in.active && (ctl_in.kind != TK_NONE) && !ctl_in.found && hit_here;
      shifting = ctl_in.active && (ctl_in.found || hit_now);

      entry_in          = entry_ff;
      carry_in_next     = carry_in;
      result_in_next    = result_in;
      ctl_in_next       = ctl_in;
      ctl_in_next.found = ctl_in.found || hit_now;

      unique case (ctl_in.kind)
         TK_INSERT: begin
            if (shifting) begin
               entry_in      = carry_in;
               carry_in_next = entry_ff;
            end
         end
         TK_DELETE: begin
            if (shifting) entry_in = next_entry;
            if (hit_now) result_in_next = entry_ff;
         end
         TK_READ: begin
            if (hit_now) result_in_next = entry_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_next;
      end
      entry_ff  <= entry_in;
      key_ff    <= key_in;
      carry_ff  <= carry_in_next;
      result_ff <= result_in_next;
      occ_ff    <= occ_in;
      k_ff      <= k_in;
   end

   assign entry      = entry_ff;
   assign ctl_out    = ctl_ff;
   assign key_out    = key_ff;
   assign carry_out  = carry_ff;
   assign result_out = result_ff;
   assign occ_out    = occ_ff;
   assign k_out      = k_ff;

endmodule

>>> hw/rtl/ordered_deque_store_core.sv
// Ordered deque store: a chain of CAPACITY cells, one entry per cell.
// A request is registered into the launch token, walks the cell chain one cell per
// cycle, is captured at the chain exit and then moves into the response register.
// No new request is taken until the last result moves into the response register; a
// response left waiting holds the next one at the chain exit and stalls the request side.
// Reset clears the count and control; cell contents stay undefined until written.
module ordered_deque_store_core import ods_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic       clock,
   input logic       reset,
   ods_req_if.sink   req_chan,
   ods_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   ods_ctl_type   ctl_c    [CAPACITY+1];
   ods_word_type  key_c    [CAPACITY+1];
   ods_word_type  carry_c  [CAPACITY+1];
   ods_word_type  result_c [CAPACITY+1];
   logic [CW-1:0] occ_c    [CAPACITY+1];
   logic [CW-1:0] k_c      [CAPACITY+1];
   ods_word_type  entry_c  [CAPACITY+1];

   logic           busy_ff, pend_ff, rsp_valid_ff;
   logic [CW-1:0]  occupancy_ff;
   ods_ctl_type    tok_ctl_ff, ctl_launch;
   ods_word_type   tok_data_ff;
   logic [CW-1:0]  tok_occ_ff, tok_k_ff, k_launch;
   ods_status_type status_pre_ff, status_launch, status_exit;
   ods_status_type done_status_ff, rsp_status_ff;
   ods_word_type   done_value_ff, rsp_value_ff;
   logic [CW-1:0]  done_count_ff, rsp_count_ff, count_exit;
   ods_op_type     op;
   logic [PW-1:0]  pos_x, occ_x;
   logic           accept, nokey;
   logic [CW+POS_W-1:0] count_wide;

   assign req_chan.ready = !busy_ff && !reset;
   assign accept         = req_chan.valid && req_chan.ready;
   assign op             = ods_op_type'(req_chan.op);
   assign pos_x          = PW'(req_chan.position);
   assign occ_x          = PW'(occupancy_ff);

   always_comb begin
      ctl_launch    = '{active: 1'b1, kind: TK_NONE, search: 1'b0, found: 1'b0};
      k_launch      = '0;
      status_launch = ST_DONE;
      priority if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR || op == OP_ORDERED_INSERT) begin
         if (occupancy_ff == CW'(CAPACITY)) begin
            status_launch = ST_FULL;
         end else begin
            ctl_launch.kind   = TK_INSERT;
            ctl_launch.search = (op == OP_ORDERED_INSERT);
            k_launch          = (op == OP_PUSH_REAR) ? occupancy_ff : '0;
         end
      end else if (occupancy_ff == '0) begin
         status_launch = ST_EMPTY;
      end else begin
         unique case (op)
            OP_POP_FRONT: begin
               ctl_launch.kind = TK_DELETE;
            end
            OP_POP_REAR: begin
               ctl_launch.kind = TK_DELETE;
               k_launch        = occupancy_ff - CW'(1);
            end
            OP_DELETE_KEY: begin
               ctl_launch.kind   = TK_DELETE;
               ctl_launch.search = 1'b1;
            end
            OP_DELETE_BEFORE: begin
               if (pos_x < PW'(2) || pos_x > occ_x) begin
                  status_launch = ST_BADPOS;
               end else begin
                  ctl_launch.kind = TK_DELETE;
                  k_launch        = CW'(pos_x - PW'(2));
               end
            end
            OP_READ: begin
               if (pos_x == '0 || pos_x > occ_x) begin
                  status_launch = ST_BADPOS;
               end else begin
                  ctl_launch.kind = TK_READ;
                  k_launch        = CW'(pos_x - PW'(1));
               end
            end
            default: ;
         endcase
      end
   end

   assign ctl_c[0]          = tok_ctl_ff;
   assign key_c[0]          = tok_data_ff;
   assign carry_c[0]        = tok_data_ff;
   assign result_c[0]       = '0;
   assign occ_c[0]          = tok_occ_ff;
   assign k_c[0]            = tok_k_ff;
   assign entry_c[CAPACITY] = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ods_cell #(.INDEX(g), .CW(CW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl_in     (ctl_c[g]),
         .key_in     (key_c[g]),
         .carry_in   (carry_c[g]),
         .result_in  (result_c[g]),
         .occ_in     (occ_c[g]),
         .k_in       (k_c[g]),
         .next_entry (entry_c[g+1]),
         .entry      (entry_c[g]),
         .ctl_out    (ctl_c[g+1]),
         .key_out    (key_c[g+1]),
         .carry_out  (carry_c[g+1]),
         .result_out (result_c[g+1]),
         .occ_out    (occ_c[g+1]),
         .k_out      (k_c[g+1])
      );
   end

   always_comb begin
      nokey       = (ctl_c[CAPACITY].kind == TK_DELETE) && ctl_c[CAPACITY].search &&
                    !ctl_c[CAPACITY].found;
      status_exit = nokey ? ST_NOKEY : status_pre_ff;
      unique case (ctl_c[CAPACITY].kind)
         TK_INSERT: count_exit = occ_c[CAPACITY] + CW'(1);
         TK_DELETE: count_exit = ctl_c[CAPACITY].found ? occ_c[CAPACITY] - CW'(1)
                                                       : occ_c[CAPACITY];
         default:   count_exit = occ_c[CAPACITY];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occupancy_ff <= '0;
         tok_ctl_ff   <= '0;
      end else begin
         tok_ctl_ff <= accept ? ctl_launch : '0;
         if (accept) busy_ff <= 1'b1;
         if (ctl_c[CAPACITY].active) begin
            pend_ff      <= 1'b1;
            occupancy_ff <= count_exit;
         end
         if (pend_ff && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
            busy_ff      <= 1'b0;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         tok_data_ff   <= req_chan.data_value;
         tok_occ_ff    <= occupancy_ff;
         tok_k_ff      <= k_launch;
         status_pre_ff <= status_launch;
      end
      if (ctl_c[CAPACITY].active) begin
         done_status_ff <= status_exit;
         done_value_ff  <= result_c[CAPACITY];
         done_count_ff  <= count_exit;
      end
      if (pend_ff && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_status_ff <= done_status_ff;
         rsp_value_ff  <= done_value_ff;
         rsp_count_ff  <= done_count_ff;
      end
   end

   assign count_wide           = {{POS_W{1'b0}}, rsp_count_ff};
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_value   = rsp_value_ff;
   assign rsp_chan.entry_count = count_wide[POS_W-1:0];

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      ctl_c[CAPACITY].active |-> busy_ff && !pend_ff)
      else $error("token left the chain with no request in flight");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_DONE) |-> rsp_value_ff == '0)
      else $error("flagged response carries a value");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !req_chan.ready)
      else $error("request taken while another is in flight");

endmodule

>>> test/ordered_deque_store_core_tb.sv
// Testbench for ordered_deque_store_core: random and directed request traffic with
// a shadow deque that predicts every response and checks it in transfer order.
// Depends on ods_pkg, ods_req_if, ods_rsp_if and the core itself.
import ods_pkg::*;

typedef struct {
   ods_status_type    status;
   ods_word_type      value;
   logic [POS_W-1:0]  count;
} deque_rsp_type;

class deque_shadow;
   ods_word_type  shadow[$];
   deque_rsp_type awaited[$];
   int            capacity;
   int            failures;

   function new(int cap);
      capacity = cap;
      failures = 0;
   endfunction

   function void note_request(ods_op_type op, ods_word_type value, logic [POS_W-1:0] pos);
      deque_rsp_type rsp;
      int            idx;
      int            n;
      n = shadow.size();
      rsp.status = ST_DONE;
      rsp.value = '0;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR, OP_ORDERED_INSERT: begin
            if (n >= capacity) begin
               rsp.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               shadow.push_front(value);
            end else if (op == OP_PUSH_REAR) begin
               shadow.push_back(value);
            end else begin
               idx = 0;
               while (idx < n && shadow[idx] < value) idx++;
               shadow.insert(idx, value);
            end
         end
         default: begin
            if (n == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               case (op)
                  OP_POP_FRONT: rsp.value = shadow.pop_front();
                  OP_POP_REAR: rsp.value = shadow.pop_back();
                  OP_DELETE_KEY: begin
                     idx = 0;
                     while (idx < n && shadow[idx] != value) idx++;
                     if (idx < n) begin
                        rsp.value = shadow[idx];
                        shadow.delete(idx);
                     end else begin
                        rsp.status = ST_NOKEY;
                     end
                  end
                  OP_DELETE_BEFORE: begin
                     if (pos < 2 || pos > n) begin
                        rsp.status = ST_BADPOS;
                     end else begin
                        rsp.value = shadow[pos - 2];
                        shadow.delete(pos - 2);
                     end
                  end
                  default: begin
                     if (pos < 1 || pos > n) rsp.status = ST_BADPOS;
                     else rsp.value = shadow[pos - 1];
                  end
               endcase
            end
         end
      endcase
      rsp.count = POS_W'(shadow.size());
      awaited.push_back(rsp);
   endfunction

   function void check_response(logic [STATUS_W-1:0] status, ods_word_type value,
                                logic [POS_W-1:0] count);
      deque_rsp_type want;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected response: status %0d value %0d count %0d",
                  $time, status, value, count);
         failures++;
         return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
         $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
         failures++;
      end
      if (value !== want.value) begin
         $display("%0t: out_value mismatch: expected %0d, got %0d", $time, want.value, value);
         failures++;
      end
      if (count !== want.count) begin
         $display("%0t: entry_count mismatch: expected %0d, got %0d",
                  $time, want.count, count);
         failures++;
      end
   endfunction
endclass

module ordered_deque_store_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int           DEPTH      = CAPACITY_DEF;
   localparam int           RAND_ITEMS = 1525;
   localparam ods_word_type WORD_MIN   = 32'sh8000_0000;
   localparam ods_word_type WORD_MAX   = 32'sh7fff_ffff;

   typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN, MIX_SORTED} mix_type;

   logic        clock;
   logic        reset;
   deque_shadow sb;

   ods_req_if req_chan ();
   ods_rsp_if rsp_chan ();

   ordered_deque_store_core #(.CAPACITY(DEPTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   function automatic ods_op_type pick_op(mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 70) begin
               case ($urandom_range(0, 2))
                  0: return OP_PUSH_FRONT;
                  1: return OP_PUSH_REAR;
                  default: return OP_ORDERED_INSERT;
               endcase
            end
         end
         MIX_DRAIN: begin
            if (r < 70) begin
               case ($urandom_range(0, 3))
                  0: return OP_POP_FRONT;
                  1: return OP_POP_REAR;
                  2: return OP_DELETE_KEY;
                  default: return OP_DELETE_BEFORE;
               endcase
            end
         end
         MIX_SORTED: begin
            if (r < 40) return OP_ORDERED_INSERT;
            if (r < 65) return OP_DELETE_KEY;
            if (r < 85) return OP_READ;
         end
         default: ;
      endcase
      return ods_op_type'($urandom_range(0, 7));
   endfunction

   function automatic ods_word_type pick_value(bit prefer_stored);
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = sb.shadow.size();
      if (n > 0 && (prefer_stored ? r < 75 : r < 10)) return sb.shadow[$urandom_range(0, n - 1)];
      r = $urandom_range(0, 99);
      if (r < 45) return ods_word_type'(int'($urandom_range(0, 15)) - 8);
      if (r < 60) begin
         case ($urandom_range(0, 3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return ods_word_type'($urandom);
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = sb.shadow.size();
      if (r < 70) return POS_W'($urandom_range(0, n + 1));
      if (r < 85) begin
         case ($urandom_range(0, 4))
            0: return POS_W'(0);
            1: return POS_W'(1);
            2: return POS_W'(2);
            3: return POS_W'(n);
            default: return POS_W'(n + 1);
         endcase
      end
      return POS_W'($urandom_range(0, 127));
   endfunction

   task automatic send_item(ods_op_type op, ods_word_type value, logic [POS_W-1:0] pos,
                            bit quiet);
      int gap;
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.data_value <= value;
      req_chan.position   <= pos;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(op, value, pos);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      // empty store on every removal and read
      send_item(OP_POP_FRONT, '0, POS_W'(0), 1'b0);
      send_item(OP_POP_REAR, WORD_MAX, POS_W'(127), 1'b0);
      send_item(OP_DELETE_KEY, '0, POS_W'(0), 1'b0);
      send_item(OP_DELETE_BEFORE, -1, POS_W'(2), 1'b0);
      send_item(OP_READ, '0, POS_W'(1), 1'b0);
      send_item(OP_PUSH_FRONT, WORD_MAX, POS_W'(0), 1'b0);
      send_item(OP_PUSH_REAR, WORD_MIN, POS_W'(127), 1'b0);
      send_item(OP_ORDERED_INSERT, '0, POS_W'(0), 1'b0);
      send_item(OP_ORDERED_INSERT, WORD_MIN, POS_W'(64), 1'b0);
      send_item(OP_PUSH_FRONT, -1, POS_W'(1), 1'b0);
      send_item(OP_READ, '0, POS_W'(0), 1'b0);
      send_item(OP_READ, '0, POS_W'(127), 1'b0);
      send_item(OP_READ, '0, POS_W'(sb.shadow.size()), 1'b0);
      send_item(OP_READ, '0, POS_W'(sb.shadow.size() + 1), 1'b0);
      send_item(OP_DELETE_BEFORE, '0, POS_W'(1), 1'b0);
      send_item(OP_DELETE_BEFORE, '0, POS_W'(sb.shadow.size() + 1), 1'b0);
      send_item(OP_DELETE_BEFORE, '0, POS_W'(sb.shadow.size()), 1'b0);
      send_item(OP_DELETE_BEFORE, '0, POS_W'(2), 1'b0);
      send_item(OP_DELETE_KEY, 32'sh1234_5678, POS_W'(0), 1'b0);
      send_item(OP_DELETE_KEY, WORD_MIN, POS_W'(0), 1'b0);
      send_item(OP_POP_REAR, '0, POS_W'(0), 1'b0);
      send_item(OP_POP_FRONT, '0, POS_W'(0), 1'b0);
      send_item(OP_POP_FRONT, '0, POS_W'(0), 1'b0);
   endtask

   initial begin
      int         sent;
      int         block_len;
      bit         quiet;
      mix_type    mix;
      ods_op_type op;
      sb = new(DEPTH);
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.op         <= OP_PUSH_FRONT;
      req_chan.data_value <= '0;
      req_chan.position   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      sent = 0;
      while (sent < RAND_ITEMS) begin
         if (sent == 0) begin
            mix = MIX_FILL;
            block_len = 200;
         end else if (sent == 200) begin
            mix = MIX_DRAIN;
            block_len = 200;
         end else begin
            mix = mix_type'($urandom_range(0, 3));
            block_len = $urandom_range(40, 160);
         end
         quiet = ($urandom_range(0, 3) == 0);
         repeat (block_len) begin
            op = pick_op(mix);
            send_item(op, pick_value(op == OP_DELETE_KEY), pick_position(), quiet);
            sent++;
         end
      end
      req_chan.valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("ordered_deque_store_core test passed");
      end else begin
         $display("ordered_deque_store_core test failed");
      end
      $finish;
   end

   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = ((taken / 40) % 3 == 0) ? 0 : pick_gap();
         // hold off long enough for the core to back up onto the request side
         if (taken == 500 || taken == 1100) gap = 400;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         sb.check_response(rsp_chan.status, rsp_chan.out_value, rsp_chan.entry_count);
         taken++;
      end
   end

   initial begin
      #5_000_000;
      $display("ordered_deque_store_core test failed");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/ods_pkg.sv
hw/rtl/ods_req_if.sv
hw/rtl/ods_rsp_if.sv
hw/rtl/ods_cell.sv
hw/rtl/ordered_deque_store_core.sv
test/ordered_deque_store_core_tb.sv
